@@ hdl/postfix_expression_evaluator_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the postfix expression evaluator
// Same-cycle and next-cycle implication checks, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PFX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define PFX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PFX_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define PFX_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ hdl/pfx_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfx_pkg
// Types, codes and constants of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pfx_pkg;

  localparam int DATA_W      = 32;
  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int DEPTH_W     = 6;
  localparam int CMD_W       = 3;
  localparam int VIDX_W      = 3;
  localparam int STAT_W      = 2;
  localparam int NUM_VARS    = 5;
  localparam int CFG_AW      = $clog2(4 * NUM_VARS);
  localparam int CFG_DW      = 32;

  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REM  = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_UNDER = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVER  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_DIVZ  = 2'd3;

  typedef logic [NUM_VARS-1:0][DATA_W-1:0] var_file_t;

  localparam var_file_t VAR_RESET = {32'd4, 32'd8, 32'd2, 32'd5, 32'd10};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOP,
    ST_RD_R,
    ST_RD_L,
    ST_EXEC,
    ST_DIV,
    ST_WB,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

@@ hdl/pfx_channels.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfx channels
// Token and result channels: valid/ready with payload.
// ----------------------------------------------------------------------------
interface pfx_tok_if import pfx_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [VIDX_W-1:0] var_index;
  logic              end_of_expr;

  modport source (output valid, output cmd, output var_index, output end_of_expr,
                  input ready);
  modport sink (input valid, input cmd, input var_index, input end_of_expr,
                output ready);
endinterface

interface pfx_res_if import pfx_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] top_value;
  logic [DEPTH_W-1:0]       depth;
  logic [STAT_W-1:0]        status;
  logic                     is_answer;

  modport source (output valid, output top_value, output depth, output status,
                  output is_answer, input ready);
  modport sink (input valid, input top_value, input depth, input status,
                input is_answer, output ready);
endinterface

@@ hdl/pfx_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/pfx_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfx_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfx_div import pfx_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  div_ctl_t          ctl,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output div_sts_t          sts,
  output logic [DATA_W-1:0] quotient,
  output logic [DATA_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DATA_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvsr;

  logic [DATA_W:0] rem_shift;
  logic [DATA_W:0] diff;

  assign rem_shift = {rem, quo[DATA_W-1]};
  assign diff      = rem_shift - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign sts.busy  = busy;
  assign sts.done  = done;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

@@ hdl/pfx_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfx_cfg
// APB register file holding the five variable values.
// ----------------------------------------------------------------------------
module pfx_cfg import pfx_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output var_file_t         vars
);

  localparam int IDX_W = CFG_AW - 2;

  logic [IDX_W-1:0] idx;
  logic             wr_en;

  assign idx    = paddr[CFG_AW-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      vars <= VAR_RESET;
    end else if (wr_en && (idx < IDX_W'(NUM_VARS))) begin
      vars[idx] <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (idx < IDX_W'(NUM_VARS)) begin
      prdata = vars[idx];
    end
  end

endmodule

@@ hdl/postfix_expression_evaluator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_unit
// Postfix token evaluator on a RAM-held operand stack.
//
//   port     dir  beat
//   token    in   cmd, var_index, end_of_expr
//   result   out  top_value, depth, status, is_answer
//   apb      in   writes/reads value_a..value_e at 4*i
//
// One token at a time. A push writes the stack, a token that only reads the
// top fetches it, add/sub/mul read both operands and write back, and div/rem
// use the divider at one quotient bit per cycle. Operands come from the stack
// RAM through its single read port, one per cycle. Reset empties the stack
// and restores the variable defaults. A stalled result is held in the output
// register while the next token is accepted and worked on.
// ----------------------------------------------------------------------------
`include "postfix_expression_evaluator_unit_assert.svh"

module postfix_expression_evaluator_unit import pfx_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  pfx_tok_if.sink           token,
  pfx_res_if.source         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  var_file_t vars;

  state_t            state, state_next;
  logic [SP_W-1:0]   sp, sp_next;
  logic [CMD_W-1:0]  cmd_q;
  logic              end_q;
  logic [DATA_W-1:0] r_val, r_val_next;
  logic [DATA_W-1:0] l_val, l_val_next;
  logic [DATA_W-1:0] res_q, res_next;
  logic [DATA_W-1:0] top_q, top_next;
  logic [STAT_W-1:0] stat_q, stat_next;

  logic                     out_valid, out_valid_next;
  logic [DATA_W-1:0]        out_top, out_top_next;
  logic [DEPTH_W-1:0]       out_depth, out_depth_next;
  logic [STAT_W-1:0]        out_stat, out_stat_next;
  logic                     out_ans, out_ans_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic [SP_W-1:0]   sp_dec1, sp_dec2;
  logic [DATA_W-1:0] push_val;
  logic              accept;

  div_ctl_t          div_ctl;
  div_sts_t          div_sts;
  logic [DATA_W-1:0] div_q, div_r;
  logic [DATA_W-1:0] mag_l, mag_r;
  logic [DATA_W-1:0] div_res;

  pfx_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .vars    (vars)
  );

  pfx_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfx_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       (div_ctl),
    .dividend  (mag_l),
    .divisor   (mag_r),
    .sts       (div_sts),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign sp_dec1 = sp - SP_W'(1);
  assign sp_dec2 = sp - SP_W'(2);
  assign accept  = token.valid && token.ready;
  assign token.ready = (state == ST_IDLE);

  assign push_val = (token.var_index < VIDX_W'(NUM_VARS)) ? vars[token.var_index] : '0;

  assign mag_l = l_val[DATA_W-1] ? (DATA_W'(0) - l_val) : l_val;
  assign mag_r = r_val[DATA_W-1] ? (DATA_W'(0) - r_val) : r_val;

  always_comb begin
    if (cmd_q == CMD_DIV) begin
      div_res = (l_val[DATA_W-1] ^ r_val[DATA_W-1]) ? (DATA_W'(0) - div_q) : div_q;
    end else begin
      div_res = l_val[DATA_W-1] ? (DATA_W'(0) - div_r) : div_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sp        <= sp_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= token.cmd;
      end_q <= token.end_of_expr;
    end
    r_val     <= r_val_next;
    l_val     <= l_val_next;
    res_q     <= res_next;
    top_q     <= top_next;
    stat_q    <= stat_next;
    out_top   <= out_top_next;
    out_depth <= out_depth_next;
    out_stat  <= out_stat_next;
    out_ans   <= out_ans_next;
  end

  always_comb begin
    state_next     = state;
    sp_next        = sp;
    r_val_next     = r_val;
    l_val_next     = l_val;
    res_next       = res_q;
    top_next       = top_q;
    stat_next      = stat_q;
    out_valid_next = out_valid && !result.ready;
    out_top_next   = out_top;
    out_depth_next = out_depth;
    out_stat_next  = out_stat;
    out_ans_next   = out_ans;
    ram_we         = 1'b0;
    ram_waddr      = sp[ADDR_W-1:0];
    ram_wdata      = push_val;
    ram_raddr      = sp_dec1[ADDR_W-1:0];
    div_ctl.start  = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          stat_next = STAT_OK;
          top_next  = '0;
          if (token.cmd == CMD_PUSH) begin
            if (sp >= SP_W'(STACK_DEPTH)) begin
              stat_next  = STAT_OVER;
              state_next = ST_TOP;
            end else begin
              ram_we     = 1'b1;
              sp_next    = sp + SP_W'(1);
              top_next   = push_val;
              state_next = ST_DONE;
            end
          end else if (token.cmd inside {[CMD_ADD:CMD_REM]}) begin
            if (sp < SP_W'(2)) begin
              stat_next  = STAT_UNDER;
              state_next = (sp != '0) ? ST_TOP : ST_DONE;
            end else begin
              state_next = ST_RD_R;
            end
          end else begin
            state_next = (sp != '0) ? ST_TOP : ST_DONE;
          end
        end
      end
      ST_TOP: begin
        top_next   = ram_rdata;
        state_next = ST_DONE;
      end
      ST_RD_R: begin
        r_val_next = ram_rdata;
        ram_raddr  = sp_dec2[ADDR_W-1:0];
        state_next = ST_RD_L;
      end
      ST_RD_L: begin
        l_val_next = ram_rdata;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (cmd_q)
          CMD_ADD: begin
            res_next   = l_val + r_val;
            state_next = ST_WB;
          end
          CMD_SUB: begin
            res_next   = l_val - r_val;
            state_next = ST_WB;
          end
          CMD_MUL: begin
            res_next   = l_val * r_val;
            state_next = ST_WB;
          end
          default: begin
            if (r_val == '0) begin
              stat_next  = STAT_DIVZ;
              top_next   = r_val;
              state_next = ST_DONE;
            end else begin
              div_ctl.start = 1'b1;
              state_next    = ST_DIV;
            end
          end
        endcase
      end
      ST_DIV: begin
        if (div_sts.done) begin
          res_next   = div_res;
          state_next = ST_WB;
        end
      end
      ST_WB: begin
        ram_we     = 1'b1;
        ram_waddr  = sp_dec2[ADDR_W-1:0];
        ram_wdata  = res_q;
        sp_next    = sp_dec1;
        top_next   = res_q;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || result.ready) begin
          out_valid_next = 1'b1;
          out_top_next   = top_q;
          out_depth_next = DEPTH_W'(sp);
          out_stat_next  = stat_q;
          out_ans_next   = 1'b0;
          if (end_q) begin
            sp_next        = '0;
            out_depth_next = '0;
            if (sp != '0) begin
              out_ans_next = 1'b1;
            end else begin
              out_top_next = '0;
              if (stat_q == STAT_OK) begin
                out_stat_next = STAT_UNDER;
              end
            end
          end
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign result.valid     = out_valid;
  assign result.top_value = out_top;
  assign result.depth     = out_depth;
  assign result.status    = out_stat;
  assign result.is_answer = out_ans;

  `PFX_ASSERT_NOW(a_sp_bound, clk, rst, 1'b1, sp <= SP_W'(STACK_DEPTH), "stack pointer past depth")
  `PFX_ASSERT_NEXT(a_one_token, clk, rst, accept, !token.ready, "token taken while busy")
  `PFX_ASSERT_NOW(a_ram_write, clk, rst, ram_we, (state == ST_IDLE) || (state == ST_WB), "stray stack write")
  `PFX_ASSERT_NOW(a_div_start, clk, rst, div_ctl.start, (r_val != '0) && !div_sts.busy, "bad divide start")
  `PFX_ASSERT_NOW(a_answer_empty, clk, rst, result.valid && result.is_answer, result.depth == '0, "answer with stack left")

endmodule
